>>> hdl/battery_level_smoother_assert.svh
// Assertion macros for the battery level smoother.
`ifndef BATTERY_LEVEL_SMOOTHER_ASSERT_SVH
`define BATTERY_LEVEL_SMOOTHER_ASSERT_SVH

`ifndef SYNTHESIS

// Property must hold at every rising clock edge outside reset.
`define BLS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define BLS_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define BLS_ASSERT(lbl, clk, rstn, prop, msg)
`define BLS_ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

>>> hdl/blsm_pkg.sv
// Shared types, constants and curve tables of the battery level smoother.
package blsm_pkg;

  // Field widths
  localparam int MV_BITS   = 13;
  localparam int LVL_BITS  = 14;
  localparam int SEL_BITS  = 2;
  localparam int IDX_BITS  = 3;
  // Largest segment span of any curve is 900 mV
  localparam int OFF_BITS  = 10;
  localparam int PROD_BITS = LVL_BITS + OFF_BITS;
  localparam int MCNT_BITS = $clog2(OFF_BITS + 1);
  localparam int DCNT_BITS = $clog2(LVL_BITS + 1);

  // Configuration register indexes
  localparam logic [1:0] REG_CURVE_SELECT = 2'd0;
  localparam logic [1:0] REG_CLAMP_MAX    = 2'd1;
  localparam logic [1:0] REG_CLAMP_MIN    = 2'd2;

  // Curve codes; the unused codes select the linear curve
  localparam logic [SEL_BITS-1:0] CURVE_BUCK = 2'd0;
  localparam logic [SEL_BITS-1:0] CURVE_LDO  = 2'd1;

  // Reset values
  localparam logic [MV_BITS-1:0]  AVG_RESET  = 13'd4200;
  localparam logic [MV_BITS-1:0]  CMAX_RESET = 13'd4200;
  localparam logic [MV_BITS-1:0]  CMIN_RESET = 13'd3200;
  localparam logic [LVL_BITS-1:0] LVL_FULL   = 14'd10000;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_RANGE,
    ST_WALK,
    ST_MSTART,
    ST_MWAIT,
    ST_DWAIT,
    ST_FIN
  } state_e;

  // Status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } ser_stat_t;

  // Index of the lowest point of a curve
  function automatic logic [IDX_BITS-1:0] crv_last(logic [SEL_BITS-1:0] sel);
    logic [IDX_BITS-1:0] r;
    unique case (sel)
      CURVE_BUCK, CURVE_LDO: r = 3'd4;
      default:               r = 3'd1;
    endcase
    return r;
  endfunction

  // Voltage of a curve point, points ordered from high to low
  function automatic logic [MV_BITS-1:0] crv_mv(logic [SEL_BITS-1:0] sel,
                                                logic [IDX_BITS-1:0] idx);
    logic [MV_BITS-1:0] r;
    unique case (sel)
      CURVE_BUCK: begin
        unique case (idx)
          3'd0:    r = 13'd4150;
          3'd1:    r = 13'd4075;
          3'd2:    r = 13'd3775;
          3'd3:    r = 13'd3450;
          default: r = 13'd3200;
        endcase
      end
      CURVE_LDO: begin
        unique case (idx)
          3'd0:    r = 13'd4150;
          3'd1:    r = 13'd4025;
          3'd2:    r = 13'd3650;
          3'd3:    r = 13'd3400;
          default: r = 13'd3200;
        endcase
      end
      default: begin
        unique case (idx)
          3'd0:    r = 13'd4200;
          default: r = 13'd3300;
        endcase
      end
    endcase
    return r;
  endfunction

  // Level of a curve point
  function automatic logic [LVL_BITS-1:0] crv_lvl(logic [SEL_BITS-1:0] sel,
                                                  logic [IDX_BITS-1:0] idx);
    logic [LVL_BITS-1:0] r;
    unique case (sel)
      CURVE_BUCK, CURVE_LDO: begin
        unique case (idx)
          3'd0:    r = 14'd10000;
          3'd1:    r = 14'd9500;
          3'd2:    r = 14'd3000;
          3'd3:    r = 14'd500;
          default: r = 14'd0;
        endcase
      end
      default: begin
        unique case (idx)
          3'd0:    r = 14'd10000;
          default: r = 14'd0;
        endcase
      end
    endcase
    return r;
  endfunction

endpackage

>>> hdl/blsm_mul.sv
// Bit-serial shift-add multiplier: level span times voltage offset.
module blsm_mul import blsm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [LVL_BITS-1:0]  mcand_i,
  input  logic [OFF_BITS-1:0]  mplier_i,
  output ser_stat_t            stat_o,
  output logic [PROD_BITS-1:0] prod_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [MCNT_BITS-1:0] cnt_q;
  logic [LVL_BITS-1:0]  mcand_q;
  logic [PROD_BITS-1:0] prod_q;
  logic [LVL_BITS:0]    sum;

  // Upper half plus multiplicand when the current multiplier bit is set
  assign sum = {1'b0, prod_q[PROD_BITS-1:OFF_BITS]}
             + (prod_q[0] ? {1'b0, mcand_q} : '0);

  // Step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == MCNT_BITS'(OFF_BITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Product register: multiplier shifts out at the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q <= mcand_i;
      prod_q  <= {{LVL_BITS{1'b0}}, mplier_i};
    end else if (busy_q) begin
      prod_q <= {sum, prod_q[OFF_BITS-1:1]};
    end
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign prod_o = prod_q;

endmodule

>>> hdl/blsm_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module blsm_div import blsm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [PROD_BITS-1:0] dividend_i,
  input  logic [OFF_BITS-1:0]  divisor_i,
  output ser_stat_t            stat_o,
  output logic [LVL_BITS-1:0]  quot_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [DCNT_BITS-1:0] cnt_q;
  logic [OFF_BITS-1:0]  dvsr_q;
  logic [OFF_BITS-1:0]  rem_q;
  logic [LVL_BITS-1:0]  quo_q;
  logic [OFF_BITS:0]    trial;
  logic [OFF_BITS:0]    diff;
  logic                 qbit;

  // Partial remainder with next dividend bit, trial subtract
  assign trial = {rem_q, quo_q[LVL_BITS-1]};
  assign diff  = trial - {1'b0, dvsr_q};
  assign qbit  = (trial >= {1'b0, dvsr_q});

  // Step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DCNT_BITS'(LVL_BITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Quotient fits LVL_BITS, so the top dividend bits start below the divisor
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvsr_q <= divisor_i;
      rem_q  <= dividend_i[PROD_BITS-1:LVL_BITS];
      quo_q  <= dividend_i[LVL_BITS-1:0];
    end else if (busy_q) begin
      rem_q <= qbit ? diff[OFF_BITS-1:0] : trial[OFF_BITS-1:0];
      quo_q <= {quo_q[LVL_BITS-2:0], qbit};
    end
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign quot_o = quo_q;

endmodule

>>> hdl/battery_level_smoother.sv
// Top level of the battery level smoother: averaging, clamp and curve map.
//
//   channel  direction  handshake                  payload
//   in       request    in_valid_i / in_stall_o    sample_mv_i, sample_error_i
//   out      result     out_valid_o / out_stall_i  level_pptt_o, average_mv_o, status_o
//   cfg      write      cfg_we_i                   cfg_index_i, cfg_wdata_i
//
// A request passes from the accept state to the finish state; an error skips the
// clamp, and an average outside the curve goes from the range check straight to
// the finish. An interpolated request adds one to four table steps, a start state,
// the multiplier's 10 steps and done, and the divider's 14 steps and done.
// One request is in work at a time; a new one is taken while a result waits.
// Reset loads the average with 4200 mV and the register reset values.
// A stalled result holds the finished request in its last state.
`include "battery_level_smoother_assert.svh"

module battery_level_smoother import blsm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [MV_BITS-1:0]  sample_mv_i,
  input  logic                sample_error_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [LVL_BITS-1:0] level_pptt_o,
  output logic [MV_BITS-1:0]  average_mv_o,
  output logic                status_o,
  // configuration
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [MV_BITS-1:0]  cfg_wdata_i
);

  state_e               state_q, state_d;
  logic [SEL_BITS-1:0]  sel_q;
  logic [MV_BITS-1:0]   cmax_q;
  logic [MV_BITS-1:0]   cmin_q;
  logic [MV_BITS-1:0]   avg_q;
  logic [MV_BITS+1:0]   sum_q;
  logic [IDX_BITS-1:0]  idx_q;
  logic [LVL_BITS-1:0]  base_q;
  logic                 frac_q;
  logic [OFF_BITS-1:0]  off_q;
  logic [OFF_BITS-1:0]  dmv_q;
  logic [LVL_BITS-1:0]  dlvl_q;
  logic                 err_q;
  logic                 out_valid_q;
  logic [LVL_BITS-1:0]  level_q;
  logic [MV_BITS-1:0]   avg_out_q;
  logic                 status_q;

  logic                 in_take;
  logic                 out_take;
  logic                 load;
  logic                 mul_start;
  logic                 div_start;
  ser_stat_t            mul_stat;
  ser_stat_t            div_stat;
  logic [PROD_BITS-1:0] prod;
  logic [LVL_BITS-1:0]  quot;
  logic [MV_BITS-1:0]   avg_new;
  logic [MV_BITS-1:0]   avg_cmax;
  logic [MV_BITS-1:0]   avg_clamp;
  logic [IDX_BITS-1:0]  last;
  logic [MV_BITS-1:0]   pt_mv;
  logic [MV_BITS-1:0]   pt_mv_up;
  logic [LVL_BITS-1:0]  pt_lvl;
  logic [LVL_BITS-1:0]  pt_lvl_up;
  logic                 walk_on;
  logic                 win_ok;

  assign in_take  = in_valid_i && !in_stall_o;
  assign out_take = out_valid_q && !out_stall_i;

  // Clamp: maximum first, then minimum, so the minimum wins
  assign avg_new   = sum_q[MV_BITS+1:2];
  assign avg_cmax  = (avg_new > cmax_q) ? cmax_q : avg_new;
  assign avg_clamp = (avg_cmax < cmin_q) ? cmin_q : avg_cmax;

  // Curve points around the current walk index
  assign last      = crv_last(sel_q);
  assign pt_mv     = crv_mv(sel_q, idx_q);
  assign pt_lvl    = crv_lvl(sel_q, idx_q);
  assign pt_mv_up  = crv_mv(sel_q, idx_q - 1'b1);
  assign pt_lvl_up = crv_lvl(sel_q, idx_q - 1'b1);
  assign walk_on   = (idx_q < last) && (avg_q < pt_mv);

  // Next state and strobes
  always_comb begin
    state_d   = state_q;
    in_stall_o = 1'b1;
    mul_start = 1'b0;
    div_start = 1'b0;
    load      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = sample_error_i ? ST_RANGE : ST_CLAMP;
        end
      end
      ST_CLAMP: state_d = ST_RANGE;
      ST_RANGE: begin
        if ((avg_q >= crv_mv(sel_q, '0)) || (avg_q < crv_mv(sel_q, last))) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (!walk_on) begin
          state_d = ST_MSTART;
        end
      end
      ST_MSTART: begin
        mul_start = 1'b1;
        state_d   = ST_MWAIT;
      end
      ST_MWAIT: begin
        if (mul_stat.done) begin
          div_start = 1'b1;
          state_d   = ST_DWAIT;
        end
      end
      ST_DWAIT: begin
        if (div_stat.done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          load    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State, configuration, stored average and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sel_q       <= CURVE_BUCK;
      cmax_q      <= CMAX_RESET;
      cmin_q      <= CMIN_RESET;
      avg_q       <= AVG_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_CURVE_SELECT: sel_q  <= cfg_wdata_i[SEL_BITS-1:0];
          REG_CLAMP_MAX:    cmax_q <= cfg_wdata_i;
          REG_CLAMP_MIN:    cmin_q <= cfg_wdata_i;
          default:          ;
        endcase
      end
      if (state_q == ST_CLAMP) begin
        avg_q <= avg_clamp;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          err_q <= sample_error_i;
          sum_q <= {2'b00, sample_mv_i} + {1'b0, avg_q, 1'b0} + {2'b00, avg_q};
        end
      end
      ST_RANGE: begin
        idx_q  <= IDX_BITS'(1);
        frac_q <= 1'b0;
        // at or above the top point gives its level, below the bottom gives zero
        base_q <= (avg_q >= crv_mv(sel_q, '0)) ? crv_lvl(sel_q, '0) : '0;
      end
      ST_WALK: begin
        if (walk_on) begin
          idx_q <= idx_q + 1'b1;
        end else begin
          frac_q <= 1'b1;
          base_q <= pt_lvl;
          dlvl_q <= pt_lvl_up - pt_lvl;
          off_q  <= OFF_BITS'(avg_q - pt_mv);
          dmv_q  <= OFF_BITS'(pt_mv_up - pt_mv);
        end
      end
      ST_FIN: begin
        if (load) begin
          level_q   <= base_q + (frac_q ? quot : '0);
          avg_out_q <= avg_q;
          status_q  <= err_q;
        end
      end
      default: ;
    endcase
  end

  blsm_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (dlvl_q),
    .mplier_i (off_q),
    .stat_o   (mul_stat),
    .prod_o   (prod)
  );

  blsm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod),
    .divisor_i  (dmv_q),
    .stat_o     (div_stat),
    .quot_o     (quot)
  );

  assign out_valid_o  = out_valid_q;
  assign level_pptt_o = level_q;
  assign average_mv_o = avg_out_q;
  assign status_o     = status_q;

  // Checks; an inverted clamp window is not checked
  assign win_ok = (cmin_q > cmax_q) || ((average_mv_o <= cmax_q) && (average_mv_o >= cmin_q));

  `BLS_ASSERT(a_level_range, clk_i, rst_ni, out_valid_o |-> level_pptt_o <= LVL_FULL, "level range")
  `BLS_ASSERT(a_avg_clamp, clk_i, rst_ni, out_valid_o && !status_o |-> win_ok, "avg outside clamp")
  `BLS_ASSERT_NEVER(a_units_excl, clk_i, rst_ni, mul_stat.busy && div_stat.busy, "units overlap")
  `BLS_ASSERT(a_take_starts, clk_i, rst_ni, in_take |=> state_q != ST_IDLE, "request not started")

endmodule

>>> dv/tb_battery_level_smoother.sv
// Self-checking testbench of the battery level smoother with a built-in predictor.
module tb_battery_level_smoother import blsm_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // Curve codes not named in the package, and result status codes
  localparam logic [SEL_BITS-1:0] CURVE_LIN   = 2'd2;
  localparam logic [SEL_BITS-1:0] CURVE_SPARE = 2'd3;
  localparam logic STAT_OK  = 1'b0;
  localparam logic STAT_ERR = 1'b1;

  // Cycles to let pass once nothing is outstanding; covers one interpolated request
  localparam int unsigned SETTLE_CYCLES = 40;
  // Long receiver hold-off, first trigger point and spacing in results
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned HOLD_FIRST    = 100;
  localparam int unsigned HOLD_SPACING  = 500;
  localparam int unsigned RAND_PHASES   = 12;
  localparam int unsigned PHASE_ITEMS   = 105;

  typedef struct {
    logic [MV_BITS-1:0] mv;
    logic               err;
  } sample_req_t;

  typedef struct {
    logic [LVL_BITS-1:0] level;
    logic [MV_BITS-1:0]  avg;
    logic                status;
  } reading_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [MV_BITS-1:0] sample_mv = '0;
  logic               sample_error = 1'b0;

  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [LVL_BITS-1:0] level_pptt;
  logic [MV_BITS-1:0]  average_mv;
  logic                status;

  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [MV_BITS-1:0] cfg_wdata = '0;

  // Predictor state, mirrors the block's registers and average
  logic [SEL_BITS-1:0] curve_sel = CURVE_BUCK;
  logic [MV_BITS-1:0]  cmax_mv   = CMAX_RESET;
  logic [MV_BITS-1:0]  cmin_mv   = CMIN_RESET;
  logic [MV_BITS-1:0]  avg_mv    = AVG_RESET;

  sample_req_t pending_q[$];
  reading_t    expected_q[$];

  int unsigned fail_count   = 0;
  int unsigned results_seen = 0;
  bit          req_taken    = 1'b0;
  bit          tx_idle_on   = 1'b1;
  bit          rx_idle_on   = 1'b1;

  battery_level_smoother uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .sample_mv_i    (sample_mv),
    .sample_error_i (sample_error),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .level_pptt_o   (level_pptt),
    .average_mv_o   (average_mv),
    .status_o       (status),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Gap length: mostly none or short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Charge level of a voltage: piecewise linear over the selected curve
  function automatic logic [LVL_BITS-1:0] charge_level(logic [SEL_BITS-1:0] sel,
                                                       logic [MV_BITS-1:0] mv);
    int unsigned knee_mv[5];
    int unsigned knee_lvl[5];
    int unsigned last;
    int unsigned k;
    int unsigned v;
    v = 32'(mv);
    knee_lvl = '{10000, 9500, 3000, 500, 0};
    last = 4;
    if (sel == CURVE_BUCK) begin
      knee_mv = '{4150, 4075, 3775, 3450, 3200};
    end else if (sel == CURVE_LDO) begin
      knee_mv = '{4150, 4025, 3650, 3400, 3200};
    end else begin
      // linear and spare codes
      knee_mv  = '{4200, 3300, 0, 0, 0};
      knee_lvl = '{10000, 0, 0, 0, 0};
      last = 1;
    end
    if (v >= knee_mv[0]) return LVL_BITS'(knee_lvl[0]);
    if (v < knee_mv[last]) return '0;
    k = 1;
    while (k < last && v < knee_mv[k]) k++;
    return LVL_BITS'(knee_lvl[k] + ((knee_lvl[k-1] - knee_lvl[k]) * (v - knee_mv[k]))
                                   / (knee_mv[k-1] - knee_mv[k]));
  endfunction

  // Advance the average by one request and give the expected reading
  function automatic reading_t smooth_step(sample_req_t req);
    reading_t    r;
    int unsigned v;
    r.status = STAT_OK;
    if (req.err) begin
      r.status = STAT_ERR;
    end else begin
      v = (int'(req.mv) + 3 * int'(avg_mv)) / 4;
      if (v > cmax_mv) v = 32'(cmax_mv);
      if (v < cmin_mv) v = 32'(cmin_mv);
      avg_mv = v[MV_BITS-1:0];
    end
    r.avg   = avg_mv;
    r.level = charge_level(curve_sel, avg_mv);
    return r;
  endfunction

  // Request driver: pops pending samples, holds while stalled, random gaps
  always @(negedge clk) begin : request_driver
    sample_req_t req;
    int unsigned tx_gap;
    if (in_valid && !req_taken) begin
      // payload stays put until taken
    end else if (tx_gap > 0) begin
      in_valid <= 1'b0;
      tx_gap--;
    end else if (pending_q.size() != 0) begin
      req = pending_q.pop_front();
      sample_mv    <= req.mv;
      sample_error <= req.err;
      in_valid     <= 1'b1;
      tx_gap = tx_idle_on ? idle_len() : 0;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result receiver: random stalls plus a periodic long hold-off
  always @(negedge clk) begin : result_receiver
    int unsigned hold_left;
    int unsigned stall_left;
    int unsigned next_hold_at;
    if (next_hold_at == 0) next_hold_at = HOLD_FIRST;
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (results_seen >= next_hold_at) begin
      out_stall <= 1'b1;
      hold_left = HOLD_CYCLES - 1;
      next_hold_at += HOLD_SPACING;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (rx_idle_on && $urandom_range(0, 99) < 25) begin
      out_stall <= 1'b1;
      stall_left = idle_len();
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: check results in order, predict each accepted request
  always @(posedge clk) begin : monitor
    reading_t    got_exp;
    sample_req_t req;
    req_taken = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          $error("unexpected result: level_pptt %0d average_mv %0d status %0d",
                 level_pptt, average_mv, status);
          fail_count++;
        end else begin
          got_exp = expected_q.pop_front();
          if (level_pptt !== got_exp.level) begin
            $error("level_pptt: expected %0d, got %0d", got_exp.level, level_pptt);
            fail_count++;
          end
          if (average_mv !== got_exp.avg) begin
            $error("average_mv: expected %0d, got %0d", got_exp.avg, average_mv);
            fail_count++;
          end
          if (status !== got_exp.status) begin
            $error("status: expected %0d, got %0d", got_exp.status, status);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        req_taken = 1'b1;
        req.mv  = sample_mv;
        req.err = sample_error;
        expected_q.push_back(smooth_step(req));
      end
    end
  end

  task automatic send(logic [MV_BITS-1:0] mv, logic err);
    sample_req_t req;
    req.mv  = mv;
    req.err = err;
    pending_q.push_back(req);
  endtask

  // Wait until every request is answered, then let the block settle
  task automatic drain();
    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [MV_BITS-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_CURVE_SELECT: curve_sel = data[SEL_BITS-1:0];
      REG_CLAMP_MAX:    cmax_mv   = data;
      REG_CLAMP_MIN:    cmin_mv   = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Called only with nothing outstanding
  task automatic apply_config(logic [SEL_BITS-1:0] sel, logic [MV_BITS-1:0] cmax,
                              logic [MV_BITS-1:0] cmin);
    cfg_write(REG_CURVE_SELECT, MV_BITS'(sel));
    cfg_write(REG_CLAMP_MAX, cmax);
    cfg_write(REG_CLAMP_MIN, cmin);
  endtask

  // Pin the average to one voltage by equal clamps, then send one sample
  task automatic pinned_sample(logic [SEL_BITS-1:0] sel, logic [MV_BITS-1:0] mv);
    apply_config(sel, mv, mv);
    send(MV_BITS'($urandom_range(0, 8191)), 1'b0);
    drain();
  endtask

  initial begin : stimulus
    int unsigned        phase;
    int unsigned        n;
    int unsigned        r;
    logic [SEL_BITS-1:0] sel;
    logic [MV_BITS-1:0]  cmax;
    logic [MV_BITS-1:0]  cmin;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed, reset settings: bottom point, full scale, errors, exact top point
    send(13'd0, 1'b0);
    send(13'd8191, 1'b0);
    send(13'd8191, 1'b0);
    send(13'd8191, 1'b1);
    send(13'd0, 1'b1);
    send(13'd4000, 1'b0);
    send(13'd8191, 1'b0);
    drain();

    // Directed: inner points, below bottom, interpolation, unused selector
    pinned_sample(CURVE_BUCK, 13'd4075);
    pinned_sample(CURVE_BUCK, 13'd3775);
    pinned_sample(CURVE_BUCK, 13'd3450);
    pinned_sample(CURVE_BUCK, 13'd3199);
    pinned_sample(CURVE_LDO, 13'd4025);
    pinned_sample(CURVE_LDO, 13'd3650);
    pinned_sample(CURVE_LDO, 13'd3400);
    pinned_sample(CURVE_LDO, 13'd4100);
    pinned_sample(CURVE_SPARE, 13'd3300);
    pinned_sample(CURVE_LIN, 13'd4199);
    pinned_sample(CURVE_LIN, 13'd3299);
    // minimum above maximum: minimum wins
    apply_config(CURVE_BUCK, 13'd3000, 13'd3500);
    send(13'd8191, 1'b0);
    send(13'd0, 1'b0);
    drain();

    // Random phases, each under its own settings
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      case (phase)
        0: begin sel = CURVE_BUCK;  cmax = 13'd4200; cmin = 13'd3200; end
        1: begin sel = CURVE_LDO;   cmax = 13'd8191; cmin = 13'd0;    end
        2: begin sel = CURVE_LIN;   cmax = 13'd8191; cmin = 13'd0;    end
        3: begin sel = CURVE_SPARE; cmax = 13'd4300; cmin = 13'd3100; end
        4: begin sel = CURVE_BUCK;  cmax = 13'd0;    cmin = 13'd0;    end
        5: begin sel = CURVE_LDO;   cmax = 13'd8191; cmin = 13'd8191; end
        default: begin
          sel  = SEL_BITS'($urandom_range(0, 3));
          cmax = MV_BITS'($urandom_range(3300, 8191));
          cmin = MV_BITS'($urandom_range(0, 3600));
        end
      endcase
      apply_config(sel, cmax, cmin);
      tx_idle_on = (phase % 3 != 1);
      rx_idle_on = (phase % 3 == 0);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        // mostly battery-range samples so the average stays on the curves
        if (r < 60) send(MV_BITS'($urandom_range(3000, 4500)), 1'b0);
        else if (r < 85) send(MV_BITS'($urandom_range(0, 8191)), 1'b0);
        else send(MV_BITS'($urandom_range(0, 8191)), 1'b1);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Run limit
  initial begin : watchdog
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/blsm_pkg.sv
hdl/blsm_mul.sv
hdl/blsm_div.sv
hdl/battery_level_smoother.sv
dv/tb_battery_level_smoother.sv
